// ===== rtl/core/mrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, constants and the CRC-16 byte update of the Modbus RTU
// read-request framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  STATION_RESET = 8'd1;

  localparam logic [2:0] POS_STATION = 3'd0;
  localparam logic [2:0] POS_FUNC    = 3'd1;
  localparam logic [2:0] POS_REG_HI  = 3'd2;
  localparam logic [2:0] POS_REG_LO  = 3'd3;
  localparam logic [2:0] POS_CNT_HI  = 3'd4;
  localparam logic [2:0] POS_CNT_LO  = 3'd5;
  localparam logic [2:0] POS_CRC_LO  = 3'd6;
  localparam logic [2:0] POS_CRC_HI  = 3'd7;

  typedef struct packed {
    logic [7:0]  func;
    logic [15:0] start_register;
    logic [15:0] register_count;
  } req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/mrf_req_buf.sv =====
// ----------------------------------------------------------------------------
// mrf_req_buf
// One-entry request register that holds the next request while the current
// frame is being sent.
// ----------------------------------------------------------------------------
module mrf_req_buf import mrf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_func,
  input  logic [15:0] in_start_register,
  input  logic [15:0] in_register_count,
  output logic        req_valid,
  output req_t        req,
  input  logic        req_take
);

  logic buf_valid_r;
  logic buf_valid_nxt;
  req_t buf_r;
  logic accept;

  assign in_stall  = buf_valid_r;
  assign accept    = in_valid && !buf_valid_r;
  assign req_valid = buf_valid_r;
  assign req       = buf_r;

  always_comb begin
    buf_valid_nxt = buf_valid_r;
    if (req_take) begin
      buf_valid_nxt = 1'b0;
    end
    if (accept) begin
      buf_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
    end else begin
      buf_valid_r <= buf_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r <= '{func: in_func, start_register: in_start_register,
                 register_count: in_register_count};
    end
  end

endmodule

// ===== rtl/core/mrf_byte_seq.sv =====
// ----------------------------------------------------------------------------
// mrf_byte_seq
// Frame byte sequencer: steps through the eight frame positions, updates
// the CRC one byte per unstalled cycle and drives the output register.
// ----------------------------------------------------------------------------
module mrf_byte_seq import mrf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  station_address,
  input  logic        req_valid,
  input  req_t        req,
  output logic        req_take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_byte
);

  logic        active_r, active_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  req_t        req_r, req_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_frame_byte_r, out_frame_byte_nxt;
  logic        out_last_byte_r, out_last_byte_nxt;
  logic        adv;
  logic        emit;
  logic        finishing;
  logic        load;
  logic [7:0]  cur_byte;

  assign adv       = !out_valid_r || !out_stall;
  assign emit      = active_r && adv;
  assign finishing = emit && (idx_r == POS_CRC_HI);
  assign load      = req_valid && (!active_r || finishing);
  assign req_take  = load;

  always_comb begin
    case (idx_r)
      POS_STATION: cur_byte = station_address;
      POS_FUNC:    cur_byte = req_r.func;
      POS_REG_HI:  cur_byte = req_r.start_register[15:8];
      POS_REG_LO:  cur_byte = req_r.start_register[7:0];
      POS_CNT_HI:  cur_byte = req_r.register_count[15:8];
      POS_CNT_LO:  cur_byte = req_r.register_count[7:0];
      POS_CRC_LO:  cur_byte = crc_r[7:0];
      default:     cur_byte = crc_r[15:8];
    endcase
  end

  always_comb begin
    active_nxt         = active_r;
    idx_nxt            = idx_r;
    crc_nxt            = crc_r;
    req_nxt            = req_r;
    out_valid_nxt      = out_valid_r;
    out_frame_byte_nxt = out_frame_byte_r;
    out_last_byte_nxt  = out_last_byte_r;
    if (adv) begin
      out_valid_nxt      = active_r;
      out_frame_byte_nxt = cur_byte;
      out_last_byte_nxt  = (idx_r == POS_CRC_HI);
    end
    if (emit) begin
      if (idx_r < POS_CRC_LO) begin
        crc_nxt = crc_byte(crc_r, cur_byte);
      end
      idx_nxt = idx_r + 3'd1;
      if (finishing) begin
        active_nxt = 1'b0;
        idx_nxt    = POS_STATION;
      end
    end
    if (load) begin
      active_nxt = 1'b1;
      idx_nxt    = POS_STATION;
      crc_nxt    = CRC_INIT;
      req_nxt    = req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= POS_STATION;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r            <= crc_nxt;
    req_r            <= req_nxt;
    out_frame_byte_r <= out_frame_byte_nxt;
    out_last_byte_r  <= out_last_byte_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_frame_byte_r;
  assign out_last_byte  = out_last_byte_r;

  // An idle sequencer always rests at the first frame position.
  a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> idx_r == POS_STATION)
    else $error("sequencer idle away from first position");

  // A new request is only loaded when one is waiting.
  a_load_req: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> req_valid)
    else $error("request loaded from an empty buffer");

  // The final byte of a frame is marked as last on the output register.
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    finishing |=> out_valid_r && out_last_byte_r)
    else $error("final frame byte not marked as last");

  // The CRC is restarted on every load.
  a_crc_init: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> crc_r == CRC_INIT && idx_r == POS_STATION)
    else $error("CRC not restarted for a new frame");

endmodule

// ===== rtl/core/modbus_read_request_framer.sv =====
// ----------------------------------------------------------------------------
// modbus_read_request_framer
// Builds eight-byte Modbus RTU read-request frames with a CRC-16 trailer.
// ----------------------------------------------------------------------------
// Each accepted request produces eight frame bytes, one per cycle while the
// output is not stalled: station address, function code, start register high
// and low, register count high and low, then the CRC-16 low and high bytes,
// with out_last_byte set on the eighth. The byte sequencer updates the CRC
// by one byte per cycle while the output is not stalled, as the six header
// bytes are sent. A one-entry request register accepts the next request while
// the current frame is still being sent, so frames follow each other without
// gaps. The station address is written through cfg_wr_en and cfg_wr_data and
// resets to 1.
module modbus_read_request_framer import mrf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_func,
  input  logic [15:0] in_start_register,
  input  logic [15:0] in_register_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_byte
);

  logic [7:0] station_r;
  logic [7:0] station_nxt;
  logic       req_valid;
  req_t       req;
  logic       req_take;

  assign station_nxt = cfg_wr_en ? cfg_wr_data : station_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= STATION_RESET;
    end else begin
      station_r <= station_nxt;
    end
  end

  mrf_req_buf u_req_buf (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_start_register (in_start_register),
    .in_register_count (in_register_count),
    .req_valid         (req_valid),
    .req               (req),
    .req_take          (req_take)
  );

  mrf_byte_seq u_byte_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .station_address (station_r),
    .req_valid       (req_valid),
    .req             (req),
    .req_take        (req_take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_byte  (out_frame_byte),
    .out_last_byte   (out_last_byte)
  );

endmodule

// ===== tb/sv/mrf_frame_checker.sv =====
// ----------------------------------------------------------------------------
// mrf_frame_checker
// Watches the request, frame and station-address ports of the Modbus RTU
// read-request framer. Every request transfer is turned into the eight frame
// bytes that it should produce: the station address, the function code, the
// start register and register count high byte first, then the CRC-16 low and
// high bytes. Each frame byte transfer is compared with the oldest byte still
// awaited. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module mrf_frame_checker import mrf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_func,
  input  logic [15:0] in_start_register,
  input  logic [15:0] in_register_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_frame_byte,
  input  logic        out_last_byte,
  output int          fail_count,
  output int          pending_bytes
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } wire_byte_t;

  wire_byte_t  awaited_bytes[$];
  logic [7:0]  station_addr;

  initial begin
    fail_count    = 0;
    pending_bytes = 0;
    station_addr  = STATION_RESET;
  end

  function automatic logic [15:0] modbus_crc16(input logic [47:0] head);
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc = crc ^ {8'h00, head[47 - 8 * i -: 8]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  task automatic queue_frame(input req_t req);
    logic [47:0] head;
    logic [15:0] crc;
    head = {station_addr, req.func, req.start_register, req.register_count};
    crc  = modbus_crc16(head);
    for (int k = 0; k < 6; k++) begin
      awaited_bytes.push_back('{frame_byte: head[47 - 8 * k -: 8], last_byte: 1'b0});
    end
    awaited_bytes.push_back('{frame_byte: crc[7:0], last_byte: 1'b0});
    awaited_bytes.push_back('{frame_byte: crc[15:8], last_byte: 1'b1});
  endtask

  task automatic report_failure(input string msg);
    $display("checker: %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    wire_byte_t want;
    req_t       req;
    if (!rst_n) begin
      station_addr = STATION_RESET;
      awaited_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_bytes.size() == 0) begin
          report_failure($sformatf("frame byte %02h with nothing awaited", out_frame_byte));
        end else begin
          want = awaited_bytes.pop_front();
          if (out_frame_byte !== want.frame_byte) begin
            report_failure($sformatf("frame_byte got %02h, expected %02h",
                                     out_frame_byte, want.frame_byte));
          end
          if (out_last_byte !== want.last_byte) begin
            report_failure($sformatf("last_byte got %b, expected %b",
                                     out_last_byte, want.last_byte));
          end
        end
      end
      if (in_valid && !in_stall) begin
        req.func           = in_func;
        req.start_register = in_start_register;
        req.register_count = in_register_count;
        queue_frame(req);
      end
      if (cfg_wr_en) begin
        station_addr = cfg_wr_data;
      end
    end
    pending_bytes = awaited_bytes.size();
  end

endmodule

// ===== tb/sv/modbus_read_request_framer_tb.sv =====
// ----------------------------------------------------------------------------
// modbus_read_request_framer_tb
// Drives read requests into the Modbus RTU request framer: a directed set of
// field extremes under the reset station address, then four phases of random
// requests, each under a fresh station address and a different mix of sender
// gaps and receiver stalls, one of them with a long receiver hold-off. The
// checker beside the block predicts and compares every frame byte.
// ----------------------------------------------------------------------------
module modbus_read_request_framer_tb import mrf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES    = 11;
  localparam int REQS_PER_PHASE  = 38;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 20;
  localparam int CYCLE_LIMIT     = 400000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_func;
  logic [15:0] in_start_register;
  logic [15:0] in_register_count;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_frame_byte;
  logic        out_last_byte;

  int fail_count;
  int pending_bytes;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_trigger = 1'b0;
  bit hold_seen = 1'b0;

  modbus_read_request_framer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_start_register (in_start_register),
    .in_register_count (in_register_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_byte    (out_frame_byte),
    .out_last_byte     (out_last_byte)
  );

  mrf_frame_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_start_register (in_start_register),
    .in_register_count (in_register_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_byte    (out_frame_byte),
    .out_last_byte     (out_last_byte),
    .fail_count        (fail_count),
    .pending_bytes     (pending_bytes)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The receiver stalls at random, or for a long counted stretch when asked.
  always @(negedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_request(input logic [7:0] func, input logic [15:0] reg_addr,
                              input logic [15:0] reg_count);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= func;
    in_start_register <= reg_addr;
    in_register_count <= reg_count;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_bytes != 0) @(negedge clk);
  endtask

  task automatic write_station(input logic [7:0] value);
    wait_idle();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [7:0]  func;
    logic [15:0] reg_addr;
    logic [15:0] reg_count;
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 8'h00;
    in_valid          = 1'b0;
    in_func           = 8'h00;
    in_start_register = 16'h0000;
    in_register_count = 16'h0000;
    out_stall         = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Field extremes and alternating patterns under the reset station address.
    send_request(8'h03, 16'h0000, 16'h0000);
    send_request(8'h04, 16'hFFFF, 16'hFFFF);
    send_request(8'h00, 16'h0000, 16'h0001);
    send_request(8'hFF, 16'hFFFF, 16'h0000);
    send_request(8'h01, 16'h8000, 16'h0080);
    send_request(8'h02, 16'h0001, 16'h8000);
    send_request(8'h03, 16'h5555, 16'hAAAA);
    send_request(8'h04, 16'hAAAA, 16'h5555);
    send_request(8'h03, 16'h006B, 16'h0003);
    send_request(8'h80, 16'h00FF, 16'hFF00);
    send_request(8'h7F, 16'hFF00, 16'h00FF);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_station(8'h00);
        1: write_station(8'hFF);
        default: write_station(8'($urandom_range(255)));
      endcase
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 66; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 66; end
        default: begin idle_pct = 38; stall_pct <= 38; end
      endcase
      for (int n = 0; n < REQS_PER_PHASE; n++) begin
        if (phase == 0 && n == 8) begin
          hold_trigger <= ~hold_trigger;
        end
        func     = ($urandom_range(1) == 1) ? 8'($urandom_range(1, 4))
                                            : 8'($urandom_range(255));
        reg_addr = 16'($urandom_range(65535));
        case ($urandom_range(7))
          0: reg_count = 16'h0000;
          1: reg_count = 16'hFFFF;
          2: reg_count = 16'($urandom_range(1, 125));
          default: reg_count = 16'($urandom_range(65535));
        endcase
        send_request(func, reg_addr, reg_count);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
